// ===== src/tekd_pkg.sv =====
// shared constants and types for the terminal escape key decoder
package tekd_pkg;

  localparam int DEF_MAX_SEQ_LEN = 16;

  localparam logic [8:0] K_UP    = 9'd256;
  localparam logic [8:0] K_DOWN  = 9'd257;
  localparam logic [8:0] K_RIGHT = 9'd258;
  localparam logic [8:0] K_LEFT  = 9'd259;
  localparam logic [8:0] K_HOME  = 9'd260;
  localparam logic [8:0] K_END   = 9'd261;
  localparam logic [8:0] K_INS   = 9'd262;
  localparam logic [8:0] K_DEL   = 9'd263;
  localparam logic [8:0] K_PGUP  = 9'd264;
  localparam logic [8:0] K_PGDN  = 9'd265;
  localparam logic [8:0] K_F0    = 9'd266;
  localparam logic [8:0] K_CPR   = 9'd279;

  localparam logic [7:0] ESC_BYTE = 8'h1B;
  localparam logic [20:0] TICK_MAX = 21'h1FFFFF;

  localparam logic CFG_ESC_EN  = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  // decode outcome classes
  typedef enum logic [2:0] {
    RES_KEY, RES_CPR, RES_INCOMPLETE, RES_FAILED, RES_UNSUP, RES_DOUBLE
  } res_t;

  // controller -> datapath commands
  typedef struct packed {
    logic step;      // apply one input beat
    logic rep_next;  // advance replay pointer
    logic rep_done;  // finish replay, clear sequence
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic start_replay; // this beat needs replay
    logic emit_one;     // this beat emits a single key
    logic rep_last;     // replay pointer at final byte
  } sts_t;

  // ss3 final byte map
  function automatic logic [9:0] ss3_map(input logic [7:0] b);
    logic [9:0] r;
    r = 10'h3FF;
    unique case (b)
      "A": r = {1'b0, K_UP};
      "B": r = {1'b0, K_DOWN};
      "C": r = {1'b0, K_RIGHT};
      "D": r = {1'b0, K_LEFT};
      "H": r = {1'b0, K_HOME};
      "F": r = {1'b0, K_END};
      "P": r = {1'b0, K_F0 + 9'd1};
      "Q": r = {1'b0, K_F0 + 9'd2};
      "R": r = {1'b0, K_F0 + 9'd3};
      "S": r = {1'b0, K_F0 + 9'd4};
      "k": r = 10'd43;
      "m": r = 10'd45;
      "j": r = 10'd42;
      "o": r = 10'd47;
      "X": r = 10'd61;
      "n": r = 10'd46;
      "l": r = 10'd44;
      "M": r = 10'd13;
      default: begin
        if (b >= "p" && b <= "y") r = {2'b00, b - 8'h40};
      end
    endcase
    return r;
  endfunction

endpackage

// ===== src/tekd_ctrl.sv =====
// controller state machine: accept, emit and replay sequencing
module tekd_ctrl import tekd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  output logic replaying,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EMIT = 3'b010,
    ST_REPL = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // input acceptance while idle or when the held key leaves
  assign out_valid = (state_r != ST_IDLE);
  assign replaying = (state_r == ST_REPL);
  assign in_ready = (state_r == ST_IDLE) || (state_r == ST_EMIT && out_ready);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    cmd.step = in_valid && in_ready;
    if (state_r == ST_REPL && out_ready) begin
      cmd.rep_next = 1'b1;
      if (sts.rep_last) begin
        cmd.rep_done = 1'b1;
        state_nxt = ST_IDLE;
      end
    end else if (state_r == ST_EMIT && out_ready) begin
      state_nxt = ST_IDLE;
    end
    if (cmd.step) begin
      if (sts.start_replay) state_nxt = ST_REPL;
      else if (sts.emit_one) state_nxt = ST_EMIT;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== src/tekd_dp.sv =====
// datapath: sequence buffer, parameters, repeat tracking and decode
module tekd_dp import tekd_pkg::*; #(
  parameter int MAX_SEQ_LEN = DEF_MAX_SEQ_LEN
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_action,
  input  logic [7:0]  in_byte,
  input  cmd_t        cmd,
  input  logic        replaying,
  output sts_t        sts,
  output logic [8:0]  out_key_code,
  output logic [7:0]  out_repeat_count,
  output logic [3:0]  out_param_count,
  output logic [15:0] out_param_first,
  output logic [15:0] out_param_second,
  output logic        out_last_of_run
);

  localparam int LW = $clog2(MAX_SEQ_LEN + 1);
  localparam int IW = $clog2(MAX_SEQ_LEN);

  logic        esc_en_r;
  logic [19:0] tmo_r;
  logic [7:0]  seq_r [MAX_SEQ_LEN];
  logic [LW-1:0] len_r, len_nxt;
  logic [3:0]  pc_r, pc_nxt;
  logic [15:0] p1_r, p1_nxt, p2_r, p2_nxt;
  logic [8:0]  prev_r, prev_nxt;
  logic        prev_v_r, prev_v_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [20:0] quiet_r, quiet_nxt;
  logic [LW-1:0] rptr_r;
  logic [8:0]  key_r;
  logic [7:0]  rep_r;
  logic [3:0]  opc_r;
  logic [15:0] op1_r, op2_r;

  logic        push;
  logic [7:0]  b1, b2, b3;
  res_t        res;
  logic [8:0]  dkey;
  logic [9:0]  smap;
  logic [8:0]  tkey;
  logic        tok;
  logic [3:0]  dig;
  logic [19:0] acc;
  logic        do_press, do_cpr, do_replay, do_forget;
  logic [8:0]  pkey;
  logic [20:0] qinc;

  assign b1 = seq_r[1];
  assign b2 = seq_r[2];
  assign b3 = seq_r[3];
  assign dig = in_byte[3:0];
  assign smap = ss3_map(in_byte);

  // tilde key table over the buffered parameter bytes
  always_comb begin
    tkey = 9'd0;
    tok = 1'b0;
    if (len_r == LW'(3)) begin
      tok = 1'b1;
      priority if (b2 == "1" || b2 == "7") tkey = K_HOME;
      else if (b2 == "4" || b2 == "8") tkey = K_END;
      else if (b2 == "2") tkey = K_INS;
      else if (b2 == "3") tkey = K_DEL;
      else if (b2 == "5") tkey = K_PGUP;
      else if (b2 == "6") tkey = K_PGDN;
      else tok = 1'b0;
    end else if (len_r == LW'(4)) begin
      if (b2 == "1" && b3 >= "0" && b3 <= "5") begin
        tok = 1'b1; tkey = K_F0 + {1'b0, b3 - 8'h30};
      end else if (b2 == "1" && b3 >= "7" && b3 <= "9") begin
        tok = 1'b1; tkey = K_F0 + 9'd6 + {1'b0, b3 - 8'h37};
      end else if (b2 == "2" && (b3 == "0" || b3 == "1")) begin
        tok = 1'b1; tkey = K_F0 + 9'd9 + {1'b0, b3 - 8'h30};
      end else if (b2 == "2" && (b3 == "3" || b3 == "4")) begin
        tok = 1'b1; tkey = K_F0 + 9'd11 + {1'b0, b3 - 8'h33};
      end
    end
  end

  // decode of one byte against the pending sequence
  always_comb begin
    res = RES_FAILED;
    dkey = 9'd0;
    push = 1'b1;
    pc_nxt = pc_r;
    p1_nxt = p1_r;
    p2_nxt = p2_r;
    acc = 20'd0;
    if (len_r == LW'(1)) begin
      if (in_byte == ESC_BYTE) begin
        res = RES_KEY; dkey = {1'b0, ESC_BYTE}; push = 1'b0;
      end else if (in_byte == "[" || in_byte == "O") res = RES_INCOMPLETE;
    end else if (len_r == LW'(2) && b1 == "O") begin
      if (smap[9]) res = RES_UNSUP;
      else begin res = RES_KEY; dkey = smap[8:0]; push = 1'b0; end
    end else if (b1 == "[") begin
      if (in_byte >= "0" && in_byte <= "9") begin
        res = RES_INCOMPLETE;
        if (pc_r == 4'd0) pc_nxt = 4'd1;
        if (pc_r <= 4'd1) begin
          acc = {4'd0, p1_r} * 20'd10 + {16'd0, dig};
          p1_nxt = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
        end else if (pc_r == 4'd2) begin
          acc = {4'd0, p2_r} * 20'd10 + {16'd0, dig};
          p2_nxt = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
        end
      end else if (in_byte == ";") begin
        res = RES_INCOMPLETE;
        pc_nxt = (pc_r == 4'd0) ? 4'd2 : ((pc_r < 4'd15) ? pc_r + 4'd1 : 4'd15);
      end else if ((in_byte >= 8'h20 && in_byte <= 8'h2F) ||
                   (in_byte >= 8'h3A && in_byte <= 8'h3F)) begin
        res = RES_INCOMPLETE;
      end else begin
        push = 1'b0;
        res = RES_KEY;
        unique case (in_byte)
          "A": dkey = K_UP;
          "B": dkey = K_DOWN;
          "C": dkey = K_RIGHT;
          "D": dkey = K_LEFT;
          "F": dkey = K_END;
          "H": dkey = K_HOME;
          "R": res = RES_CPR;
          "~": begin
            if (tok) dkey = tkey;
            else begin res = RES_UNSUP; push = 1'b1; end
          end
          default: begin
            push = 1'b1;
            res = (in_byte >= 8'h40 && in_byte <= 8'h7F) ? RES_UNSUP : RES_FAILED;
          end
        endcase
      end
    end
  end

  // per-beat control decisions
  assign qinc = (quiet_r < TICK_MAX) ? quiet_r + 21'd1 : quiet_r;
  always_comb begin
    do_press = 1'b0; do_cpr = 1'b0; do_replay = 1'b0; do_forget = 1'b0;
    pkey = {1'b0, in_byte};
    if (in_action) begin
      if (qinc > {1'b0, tmo_r}) begin
        do_forget = 1'b1;
        do_replay = (len_r != '0);
      end
    end else if (len_r != '0) begin
      unique case (res)
        RES_FAILED: do_replay = 1'b1;
        RES_INCOMPLETE: do_replay = (len_r + LW'(1) >= LW'(MAX_SEQ_LEN));
        RES_UNSUP: do_forget = 1'b1;
        RES_CPR: do_cpr = 1'b1;
        default: begin do_press = 1'b1; pkey = dkey; end
      endcase
    end else if (!(esc_en_r && in_byte == ESC_BYTE)) begin
      do_press = 1'b1;
    end
  end

  assign sts.start_replay = do_replay;
  assign sts.emit_one = do_press || do_cpr;
  assign sts.rep_last = (rptr_r + LW'(1) == len_r);

  // next values of repeat tracking, quiet counter and sequence length
  always_comb begin
    prev_nxt = prev_r; prev_v_nxt = prev_v_r; cnt_nxt = cnt_r;
    if (do_press) begin
      if (prev_v_r && prev_r == pkey) begin
        if (cnt_r != 8'hFF) cnt_nxt = cnt_r + 8'd1;
      end else begin
        prev_nxt = pkey; prev_v_nxt = 1'b1; cnt_nxt = 8'd1;
      end
    end
    if (do_cpr || do_forget || do_replay) begin
      prev_nxt = 9'd0; prev_v_nxt = 1'b0; cnt_nxt = 8'd0;
    end
    quiet_nxt = in_action ? qinc : 21'd0;
    len_nxt = len_r;
    if (!in_action && len_r == '0 && esc_en_r && in_byte == ESC_BYTE) len_nxt = LW'(1);
    else if (!in_action && len_r != '0 && push && len_r < LW'(MAX_SEQ_LEN))
      len_nxt = len_r + LW'(1);
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_en_r <= 1'b1;
      tmo_r <= 20'd100;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ESC_EN) esc_en_r <= cfg_data[0];
      else tmo_r <= cfg_data;
    end
  end

  // sequence byte buffer
  always_ff @(posedge clk) begin
    if (cmd.step && !in_action && len_r < LW'(MAX_SEQ_LEN) &&
        ((len_r == '0 && esc_en_r && in_byte == ESC_BYTE) || (len_r != '0 && push)))
      seq_r[len_r[IW-1:0]] <= in_byte;
  end

  // state and output holding registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0; pc_r <= '0; p1_r <= '0; p2_r <= '0;
      prev_r <= '0; prev_v_r <= 1'b0; cnt_r <= '0; quiet_r <= '0;
      rptr_r <= '0;
    end else begin
      if (cmd.rep_next) rptr_r <= rptr_r + LW'(1);
      if (cmd.rep_done) begin
        len_r <= '0; pc_r <= '0; p1_r <= '0; p2_r <= '0; rptr_r <= '0;
      end
      if (cmd.step) begin
        quiet_r <= quiet_nxt;
        prev_r <= prev_nxt; prev_v_r <= prev_v_nxt; cnt_r <= cnt_nxt;
        rptr_r <= '0;
        if (do_press || do_cpr || do_forget && !in_action) begin
          len_r <= '0; pc_r <= '0; p1_r <= '0; p2_r <= '0;
        end else begin
          len_r <= len_nxt;
          if (!in_action && len_r != '0) begin
            pc_r <= pc_nxt; p1_r <= p1_nxt; p2_r <= p2_nxt;
          end
        end
      end
    end
  end

  // held single result
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      key_r <= do_cpr ? K_CPR : pkey;
      rep_r <= do_cpr ? 8'd1 : cnt_nxt;
      opc_r <= (do_press && len_r == '0) ? 4'd0 : pc_nxt;
      op1_r <= (do_press && len_r == '0) ? 16'd0 : p1_nxt;
      op2_r <= (do_press && len_r == '0) ? 16'd0 : p2_nxt;
    end
  end

  // output mux between replay and held key
  always_comb begin
    if (replaying) begin
      out_key_code = {1'b0, seq_r[rptr_r[IW-1:0]]};
      out_repeat_count = 8'd1;
      out_param_count = 4'd0;
      out_param_first = 16'd0;
      out_param_second = 16'd0;
      out_last_of_run = sts.rep_last;
    end else begin
      out_key_code = key_r;
      out_repeat_count = rep_r;
      out_param_count = opc_r;
      out_param_first = op1_r;
      out_param_second = op2_r;
      out_last_of_run = 1'b1;
    end
  end

endmodule

// ===== src/terminal_escape_key_decoder_core.sv =====
// Terminal escape key decoder: bytes and ticks in, decoded keys out. One beat
// is taken when the block is idle; it yields no key, one key in the next cycle,
// or a replay of up to MAX_SEQ_LEN buffered bytes at one byte per cycle while
// out_ready is high, paced by the replay pointer over the sequence buffer.
// A new beat is taken in the same cycle a single held key leaves.
module terminal_escape_key_decoder_core import tekd_pkg::*; #(
  parameter int MAX_SEQ_LEN = DEF_MAX_SEQ_LEN
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  out_key_code,
  output logic [7:0]  out_repeat_count,
  output logic [3:0]  out_param_count,
  output logic [15:0] out_param_first,
  output logic [15:0] out_param_second,
  output logic        out_last_of_run
);

  cmd_t cmd;
  sts_t sts;
  logic replaying;

  assign cfg_ready = 1'b1;

  // controller
  tekd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_ready, .out_valid,
    .replaying, .sts, .cmd
  );

  // datapath
  tekd_dp #(.MAX_SEQ_LEN(MAX_SEQ_LEN)) u_dp (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data, .in_action, .in_byte,
    .cmd, .replaying, .sts, .out_key_code, .out_repeat_count, .out_param_count,
    .out_param_first, .out_param_second, .out_last_of_run
  );

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the terminal escape key decoder core: scoreboard with a key predictor
`timescale 1ns / 1ps

module tb;
  import tekd_pkg::*;

  localparam int SEQ_MAX = 16;
  localparam int CYCLE_LIMIT = 600000;

  // one decoded key beat
  typedef struct {
    bit [8:0]  key;
    bit [7:0]  rep;
    bit [3:0]  pc;
    bit [15:0] p1;
    bit [15:0] p2;
    bit        last;
  } key_beat_t;

  class key_scoreboard;
    localparam int DEC_INCOMPLETE = -1;
    localparam int DEC_FAILED = -2;
    localparam int DEC_UNSUP = -3;

    bit        esc_en;
    bit [19:0] quiet_limit;
    bit [7:0]  seq_buf[SEQ_MAX];
    int        seq_len, pseen, val1, val2, prev, press_cnt, quiet;
    bit        prev_ok;
    key_beat_t expected_keys[$];
    key_beat_t run_keys[$];
    int        fails;

    function new();
      esc_en = 1'b1;
      quiet_limit = 20'd100;
      seq_len = 0; pseen = 0; val1 = 0; val2 = 0;
      prev = 0; prev_ok = 0; press_cnt = 0; quiet = 0;
      fails = 0;
    endfunction

    function void set_reg(bit idx, bit [19:0] data);
      if (idx == CFG_ESC_EN) esc_en = data[0];
      else quiet_limit = data;
    endfunction

    function int pending();
      return expected_keys.size();
    endfunction

    function void put_key(int key, int rep, int pc, int p1, int p2);
      key_beat_t k;
      k.key = 9'(key); k.rep = 8'(rep); k.pc = 4'(pc);
      k.p1 = 16'(p1); k.p2 = 16'(p2); k.last = 0;
      run_keys = {run_keys, k};
    endfunction

    function void clear_seq();
      seq_len = 0; pseen = 0; val1 = 0; val2 = 0;
    endfunction

    function void forget_prev();
      prev_ok = 0; prev = 0; press_cnt = 0;
    endfunction

    function void push_byte(bit [7:0] b);
      if (seq_len < SEQ_MAX) begin
        seq_buf[seq_len] = b;
        seq_len++;
      end
    endfunction

    function void replay();
      for (int i = 0; i < seq_len; i++) put_key(seq_buf[i], 1, 0, 0, 0);
      clear_seq();
      forget_prev();
    endfunction

    function void press(int key);
      if (prev_ok && prev == key) begin
        if (press_cnt < 255) press_cnt++;
      end else begin
        prev = key; prev_ok = 1; press_cnt = 1;
      end
      put_key(key, press_cnt, pseen, val1, val2);
      clear_seq();
    endfunction

    function int ss3_key(bit [7:0] b);
      case (b)
        "A": return K_UP;
        "B": return K_DOWN;
        "C": return K_RIGHT;
        "D": return K_LEFT;
        "H": return K_HOME;
        "F": return K_END;
        "P": return K_F0 + 1;
        "Q": return K_F0 + 2;
        "R": return K_F0 + 3;
        "S": return K_F0 + 4;
        "k": return 43;
        "m": return 45;
        "j": return 42;
        "o": return 47;
        "X": return 61;
        "n": return 46;
        "l": return 44;
        "M": return 13;
        default: ;
      endcase
      if (b >= "p" && b <= "y") return 48 + (b - "p");
      return DEC_UNSUP;
    endfunction

    function int tilde_key();
      bit [7:0] a, c;
      a = seq_buf[2];
      c = seq_buf[3];
      if (seq_len == 3) begin
        if (a == "1" || a == "7") return K_HOME;
        if (a == "4" || a == "8") return K_END;
        if (a == "2") return K_INS;
        if (a == "3") return K_DEL;
        if (a == "5") return K_PGUP;
        if (a == "6") return K_PGDN;
        return DEC_UNSUP;
      end
      if (seq_len == 4) begin
        if (a == "1") begin
          if (c >= "0" && c <= "5") return K_F0 + (c - "0");
          if (c >= "7" && c <= "9") return K_F0 + 6 + (c - "7");
        end else if (a == "2") begin
          if (c == "0" || c == "1") return K_F0 + 9 + (c - "0");
          if (c == "3" || c == "4") return K_F0 + 11 + (c - "3");
        end
      end
      return DEC_UNSUP;
    endfunction

    // decimal parameter digit, saturating, only first two kept
    function void add_digit(bit [7:0] b);
      int x;
      if (pseen == 0) pseen = 1;
      if (pseen == 1) begin
        x = val1 * 10 + (b - "0");
        val1 = (x > 65535) ? 65535 : x;
      end else if (pseen == 2) begin
        x = val2 * 10 + (b - "0");
        val2 = (x > 65535) ? 65535 : x;
      end
    endfunction

    function int csi_byte(bit [7:0] b);
      int k;
      if (b >= "0" && b <= "9") begin
        add_digit(b);
        push_byte(b);
        return DEC_INCOMPLETE;
      end
      if (b == ";") begin
        pseen = (pseen == 0) ? 2 : ((pseen < 15) ? pseen + 1 : 15);
        push_byte(b);
        return DEC_INCOMPLETE;
      end
      if ((b >= 8'h20 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h3F)) begin
        push_byte(b);
        return DEC_INCOMPLETE;
      end
      case (b)
        "A": return K_UP;
        "B": return K_DOWN;
        "C": return K_RIGHT;
        "D": return K_LEFT;
        "F": return K_END;
        "H": return K_HOME;
        "R": return K_CPR;
        "~": begin
          k = tilde_key();
          if (k == DEC_UNSUP) push_byte(b);
          return k;
        end
        default: ;
      endcase
      push_byte(b);
      return (b >= 8'h40 && b <= 8'h7F) ? DEC_UNSUP : DEC_FAILED;
    endfunction

    function int decode(bit [7:0] b);
      int k;
      if (seq_len == 1) begin
        if (b == ESC_BYTE) return ESC_BYTE;
        push_byte(b);
        return (b == "[" || b == "O") ? DEC_INCOMPLETE : DEC_FAILED;
      end
      if (seq_len == 2 && seq_buf[1] == "O") begin
        k = ss3_key(b);
        if (k == DEC_UNSUP) push_byte(b);
        return k;
      end
      if (seq_len >= 2 && seq_buf[1] == "[") return csi_byte(b);
      push_byte(b);
      return DEC_FAILED;
    endfunction

    // predict the keys caused by one accepted input beat
    function void note_input(bit act, bit [7:0] b);
      int k;
      run_keys.delete();
      if (act) begin
        if (quiet < TICK_MAX) quiet++;
        if (quiet > quiet_limit) begin
          forget_prev();
          if (seq_len > 0) replay();
        end
      end else begin
        quiet = 0;
        if (seq_len > 0) begin
          k = decode(b);
          if (k == DEC_FAILED) replay();
          else if (k == DEC_INCOMPLETE) begin
            if (seq_len >= SEQ_MAX) replay();
          end else if (k == DEC_UNSUP) begin
            clear_seq();
            forget_prev();
          end else if (k == K_CPR) begin
            put_key(K_CPR, 1, pseen, val1, val2);
            clear_seq();
            forget_prev();
          end else press(k);
        end else if (esc_en && b == ESC_BYTE) push_byte(b);
        else press(b);
      end
      if (run_keys.size() > 0) run_keys[run_keys.size() - 1].last = 1;
      expected_keys = {expected_keys, run_keys};
    endfunction

    function void check_key(key_beat_t got);
      key_beat_t e;
      if (expected_keys.size() == 0) begin
        $error("unexpected key beat key_code=%0d", got.key);
        fails++;
        return;
      end
      e = expected_keys.pop_front();
      if (got.key != e.key) begin
        $error("key_code expected %0d actual %0d", e.key, got.key); fails++;
      end
      if (got.rep != e.rep) begin
        $error("repeat_count expected %0d actual %0d", e.rep, got.rep); fails++;
      end
      if (got.pc != e.pc) begin
        $error("param_count expected %0d actual %0d", e.pc, got.pc); fails++;
      end
      if (got.p1 != e.p1) begin
        $error("param_first expected %0d actual %0d", e.p1, got.p1); fails++;
      end
      if (got.p2 != e.p2) begin
        $error("param_second expected %0d actual %0d", e.p2, got.p2); fails++;
      end
      if (got.last != e.last) begin
        $error("last_of_run expected %0d actual %0d", e.last, got.last); fails++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = 0;
  logic [19:0] cfg_data = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_action = 0;
  logic [7:0]  in_byte = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [8:0]  out_key_code;
  logic [7:0]  out_repeat_count;
  logic [3:0]  out_param_count;
  logic [15:0] out_param_first;
  logic [15:0] out_param_second;
  logic        out_last_of_run;

  key_scoreboard sb = new();
  bit calm = 0;
  bit hold_req = 0;
  int hold_cnt = 0;
  int cycles = 0;
  int sent = 0;

  terminal_escape_key_decoder_core dut (.*);

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("terminal_escape_key_decoder_core: mismatch");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_cnt = 400;
      out_ready <= 0;
    end else begin
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
    end
  end

  // result monitor
  always @(posedge clk) begin
    key_beat_t got;
    if (rst_n && out_valid && out_ready) begin
      got.key = out_key_code; got.rep = out_repeat_count; got.pc = out_param_count;
      got.p1 = out_param_first; got.p2 = out_param_second; got.last = out_last_of_run;
      sb.check_key(got);
    end
  end

  // one input beat, with an optional random gap first
  task automatic send(bit act, bit [7:0] b);
    if (!calm && $urandom_range(99) < 26) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_action <= act;
    in_byte <= b;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(act, b);
    sent++;
  endtask

  task automatic send_byte(bit [7:0] b);
    send(0, b);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(bit idx, bit [19:0] data);
    drain();
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_reg(idx, data);
  endtask

  task automatic send_digits(int n);
    repeat (n) send_byte(8'h30 + 8'($urandom_range(9)));
  endtask

  // one random sequence, mostly well formed
  task automatic random_seq();
    int r, np;
    bit [7:0] ss3_ok[] = '{"A", "B", "C", "D", "H", "F", "P", "Q", "R", "S", "k", "m",
                           "j", "o", "X", "n", "l", "M", "p", "y", "t"};
    bit [7:0] csi_fin[] = '{"A", "B", "C", "D", "F", "H", "R", "~", "~", "~"};
    r = $urandom_range(99);
    if (r < 20) send_byte(8'($urandom_range(255)));
    else if (r < 35) begin
      send_byte(ESC_BYTE);
      send_byte("O");
      send_byte($urandom_range(3) != 0 ? ss3_ok[$urandom_range(ss3_ok.size() - 1)]
                                       : 8'($urandom_range(255)));
    end else if (r < 65) begin
      send_byte(ESC_BYTE);
      send_byte("[");
      np = $urandom_range(3);
      for (int i = 0; i < np; i++) begin
        if (i > 0 || $urandom_range(5) == 0) send_byte(";");
        send_digits($urandom_range(1, (np == 1) ? 2 : 6));
      end
      if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)));
      else send_byte(csi_fin[$urandom_range(csi_fin.size() - 1)]);
    end else if (r < 72) begin
      send_byte(ESC_BYTE);
      send_byte(ESC_BYTE);
    end else if (r < 82) begin
      repeat ($urandom_range(1, 8)) send(1, 8'($urandom_range(255)));
    end else if (r < 86) begin
      send_byte(ESC_BYTE);
      send_byte("[");
      repeat (15) send_byte($urandom_range(3) == 0 ? ";" : 8'h30 + 8'($urandom_range(9)));
    end else if (r < 93) begin
      send_byte(ESC_BYTE);
      send_byte(8'($urandom_range(255)));
    end else send(1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  task automatic random_phase(int n);
    int stop;
    stop = sent + n;
    while (sent < stop) random_seq();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, plain control keys, each sequence form
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h0C);
    send_byte(8'h02);
    send_byte(8'h02);
    send_byte(ESC_BYTE); send_byte(ESC_BYTE);
    send_byte(ESC_BYTE); send_byte("O"); send_byte("A");
    send_byte(ESC_BYTE); send_byte("[");
    send_byte(";"); send_byte("5"); send_byte("C");
    send_byte(ESC_BYTE); send_byte("["); send_byte("1"); send_byte(";");
    send_byte("2"); send_byte(";"); send_byte("3"); send_byte("R");
    send_byte(ESC_BYTE); send_byte("["); send_byte("2"); send_byte("4"); send_byte("~");
    send_byte(ESC_BYTE); send_byte("x");
    send(1, 8'hA5);

    write_reg(CFG_ESC_EN, 20'd1);
    write_reg(CFG_TIMEOUT, 20'd100);
    random_phase(80);
    // leave a sequence pending, then turn escapes off
    send_byte(ESC_BYTE);
    send_byte("[");
    write_reg(CFG_ESC_EN, 20'd0);
    write_reg(CFG_TIMEOUT, 20'd1);
    // long receiver hold-off while the sender keeps offering
    hold_req = 1;
    random_phase(40);
    drain();
    random_phase(20);

    write_reg(CFG_ESC_EN, 20'd1);
    write_reg(CFG_TIMEOUT, 20'd3);
    calm = 1;
    random_phase(40);
    calm = 0;
    random_phase(50);

    write_reg(CFG_TIMEOUT, 20'hFFFFF);
    random_phase(40);

    drain();
    if (sb.fails == 0) $display("terminal_escape_key_decoder_core: match");
    else $display("terminal_escape_key_decoder_core: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
src/tekd_pkg.sv
src/tekd_ctrl.sv
src/tekd_dp.sv
src/terminal_escape_key_decoder_core.sv
tb/sv/tb.sv
